// File: sv/presence_zone_hysteresis_macros.svh
// assertion macros for the presence detector checker
`ifndef PRESENCE_ZONE_HYSTERESIS_MACROS_SVH
`define PRESENCE_ZONE_HYSTERESIS_MACROS_SVH

// same-cycle implication, quiet while reset is asserted
`define PZH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet while reset is asserted
`define PZH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/pzh_pkg.sv
// shared types and constants for the presence zone hysteresis detector
package pzh_pkg;

	// register widths
	localparam int unsigned THR_W   = 13;
	localparam int unsigned EDEB_W  = 4;
	localparam int unsigned HYST_W  = 11;
	localparam int unsigned LDEB_W  = 5;
	localparam int unsigned TOUT_W  = 14;
	localparam int unsigned CFG_W   = 14;
	localparam int unsigned CIDX_W  = 3;

	// field widths
	localparam int unsigned RANGE_W = 16;
	localparam int unsigned CONF_W  = 8;
	localparam int unsigned TS_W    = 32;

	// register indexes
	localparam logic [CIDX_W-1:0] REG_ENTER_THR  = 3'd0;
	localparam logic [CIDX_W-1:0] REG_ENTER_DEB  = 3'd1;
	localparam logic [CIDX_W-1:0] REG_HYST       = 3'd2;
	localparam logic [CIDX_W-1:0] REG_LEAVE_DEB  = 3'd3;
	localparam logic [CIDX_W-1:0] REG_LOST_TOUT  = 3'd4;

	// register reset values
	localparam logic [THR_W-1:0]  THR_RST  = 13'd1500;
	localparam logic [EDEB_W-1:0] EDEB_RST = 4'd3;
	localparam logic [HYST_W-1:0] HYST_RST = 11'd200;
	localparam logic [LDEB_W-1:0] LDEB_RST = 5'd5;
	localparam logic [TOUT_W-1:0] TOUT_RST = 14'd2000;

	// lowest confidence that makes a sample trusted
	localparam logic [CONF_W-1:0] CONF_MIN = 8'd12;

	// word kinds
	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_RESET  = 1'b1;

	// edge codes on the result word
	typedef enum logic [1:0] {
		EDGE_NONE  = 2'd0,
		EDGE_ENTER = 2'd1,
		EDGE_LEAVE = 2'd2
	} edge_t;

endpackage

// File: sv/presence_zone_hysteresis.sv
// Presence zone detector: the input word and then its result are registered.
// Throughput one word per clock: input register, single pass of compare and
// count logic, result register; stall only when both stages are held.
// Asynchronous active-low reset clears the pipeline, the zone state, the run
// counters and the last trusted time, and restores register defaults.
module presence_zone_hysteresis #(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration writes
	input  logic                          cfg_we,
	input  logic [pzh_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [pzh_pkg::CFG_W-1:0]     cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          mode,
	input  logic                          sample_valid,
	input  logic [pzh_pkg::RANGE_W-1:0]   distance_mm,
	input  logic [pzh_pkg::CONF_W-1:0]    confidence,
	input  logic [pzh_pkg::TS_W-1:0]      timestamp_ms,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    edge_res,
	output logic                          in_zone
);

	// stored time bits: the timestamp field never carries more than its own width
	localparam int unsigned SW = (TIME_WIDTH < pzh_pkg::TS_W) ? TIME_WIDTH : pzh_pkg::TS_W;

	// configuration registers
	logic [pzh_pkg::THR_W-1:0]  enter_thr_q;
	logic [pzh_pkg::EDEB_W-1:0] enter_deb_q;
	logic [pzh_pkg::HYST_W-1:0] hyst_q;
	logic [pzh_pkg::LDEB_W-1:0] leave_deb_q;
	logic [pzh_pkg::TOUT_W-1:0] lost_tout_q;

	// tracker state
	logic                        occupied_q;
	logic [pzh_pkg::EDEB_W-1:0]  enter_run_q;
	logic [pzh_pkg::LDEB_W-1:0]  leave_run_q;
	logic [SW-1:0]               last_trusted_q;

	// input stage
	logic                        valid_s1;
	logic                        mode_s1;
	logic                        sample_valid_s1;
	logic [pzh_pkg::RANGE_W-1:0] range_s1;
	logic [pzh_pkg::CONF_W-1:0]  conf_s1;
	logic [SW-1:0]               ts_s1;

	// result stage
	logic                        valid_s2;
	pzh_pkg::edge_t              edge_s2;
	logic                        in_zone_s2;

	// next-state logic
	logic                        advance;
	logic                        accept;
	logic                        trusted;
	logic                        close_hit;
	logic                        far_hit;
	logic                        lost_hit;
	logic [pzh_pkg::RANGE_W:0]   far_limit;
	logic [TIME_WIDTH-1:0]       gap;
	logic [pzh_pkg::EDEB_W-1:0]  enter_inc;
	logic [pzh_pkg::LDEB_W-1:0]  leave_inc;
	logic                        occupied_d;
	logic [pzh_pkg::EDEB_W-1:0]  enter_run_d;
	logic [pzh_pkg::LDEB_W-1:0]  leave_run_d;
	pzh_pkg::edge_t              edge_d;

	// handshake: the input stage moves on whenever the result register is free
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// configuration write port, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enter_thr_q <= pzh_pkg::THR_RST;
			enter_deb_q <= pzh_pkg::EDEB_RST;
			hyst_q      <= pzh_pkg::HYST_RST;
			leave_deb_q <= pzh_pkg::LDEB_RST;
			lost_tout_q <= pzh_pkg::TOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pzh_pkg::REG_ENTER_THR: enter_thr_q <= cfg_data[pzh_pkg::THR_W-1:0];
				pzh_pkg::REG_ENTER_DEB: enter_deb_q <= cfg_data[pzh_pkg::EDEB_W-1:0];
				pzh_pkg::REG_HYST:      hyst_q      <= cfg_data[pzh_pkg::HYST_W-1:0];
				pzh_pkg::REG_LEAVE_DEB: leave_deb_q <= cfg_data[pzh_pkg::LDEB_W-1:0];
				pzh_pkg::REG_LOST_TOUT: lost_tout_q <= cfg_data[pzh_pkg::TOUT_W-1:0];
				default: ;
			endcase
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1         <= mode;
			sample_valid_s1 <= sample_valid;
			range_s1        <= distance_mm;
			conf_s1         <= confidence;
			ts_s1           <= timestamp_ms[SW-1:0];
		end
	end

	// sample classification
	assign trusted   = sample_valid_s1 && (conf_s1 >= pzh_pkg::CONF_MIN);
	assign close_hit = trusted && (range_s1 < pzh_pkg::RANGE_W'(enter_thr_q));
	assign far_limit = (pzh_pkg::RANGE_W+1)'(enter_thr_q) + (pzh_pkg::RANGE_W+1)'(hyst_q);
	assign far_hit   = trusted && ({1'b0, range_s1} > far_limit);
	assign gap       = TIME_WIDTH'(ts_s1) - TIME_WIDTH'(last_trusted_q);
	assign lost_hit  = !trusted && (gap > TIME_WIDTH'(lost_tout_q));

	// saturating run increments
	assign enter_inc = (&enter_run_q) ? enter_run_q : enter_run_q + pzh_pkg::EDEB_W'(1);
	assign leave_inc = (&leave_run_q) ? leave_run_q : leave_run_q + pzh_pkg::LDEB_W'(1);

	// zone decision for the word in the input stage
	always_comb begin
		occupied_d  = occupied_q;
		enter_run_d = enter_run_q;
		leave_run_d = leave_run_q;
		edge_d      = pzh_pkg::EDGE_NONE;
		if (mode_s1 == pzh_pkg::MODE_RESET) begin
			enter_run_d = '0;
			leave_run_d = '0;
			if (occupied_q) begin
				occupied_d = 1'b0;
				edge_d     = pzh_pkg::EDGE_LEAVE;
			end
		end else if (!occupied_q) begin
			if (close_hit) begin
				enter_run_d = enter_inc;
				if (enter_inc >= enter_deb_q) begin
					occupied_d  = 1'b1;
					enter_run_d = '0;
					leave_run_d = '0;
					edge_d      = pzh_pkg::EDGE_ENTER;
				end
			end else begin
				enter_run_d = '0;
			end
		end else begin
			if (far_hit) begin
				leave_run_d = leave_inc;
				if (leave_inc >= leave_deb_q) begin
					occupied_d  = 1'b0;
					enter_run_d = '0;
					leave_run_d = '0;
					edge_d      = pzh_pkg::EDGE_LEAVE;
				end
			end else if (lost_hit) begin
				occupied_d  = 1'b0;
				enter_run_d = '0;
				leave_run_d = '0;
				edge_d      = pzh_pkg::EDGE_LEAVE;
			end else begin
				leave_run_d = '0;
			end
		end
	end

	// tracker state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupied_q     <= 1'b0;
			enter_run_q    <= '0;
			leave_run_q    <= '0;
			last_trusted_q <= '0;
		end else if (advance) begin
			occupied_q  <= occupied_d;
			enter_run_q <= enter_run_d;
			leave_run_q <= leave_run_d;
			if ((mode_s1 == pzh_pkg::MODE_SAMPLE) && trusted) begin
				last_trusted_q <= ts_s1;
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			edge_s2    <= edge_d;
			in_zone_s2 <= occupied_d;
		end
	end

	assign out_valid = valid_s2;
	assign edge_res  = edge_s2;
	assign in_zone   = in_zone_s2;

endmodule

// File: sv/pzh_checker.sv
// port-level checker for the presence zone detector and its bind
`include "presence_zone_hysteresis_macros.svh"

module pzh_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] edge_res,
	input logic       in_zone
);

	// a held result word keeps its contents
	`PZH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(edge_res) && $stable(in_zone), "result word changed while stalled")

	// an enter edge always reports the zone as occupied
	`PZH_ASSERT_NOW(a_enter_in_zone, out_valid && (edge_res == pzh_pkg::EDGE_ENTER), in_zone, "enter edge without presence")

	// a leave edge always reports the zone as empty
	`PZH_ASSERT_NOW(a_leave_out_zone, out_valid && (edge_res == pzh_pkg::EDGE_LEAVE), !in_zone, "leave edge with presence")

	// the input side only backs up behind a stalled result word
	`PZH_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled while result side free")

endmodule

bind presence_zone_hysteresis pzh_checker u_pzh_checker (.*);
